// ===== rtl/core/mhtb_pkg.sv =====
`default_nettype none
package mhtb_pkg;

    // table geometry
    localparam int TABLE_WORDS = 8;
    localparam int MAX_WORDS   = 8;
    localparam int WORD_W      = 32;
    localparam int SEL_W       = 3;
    localparam int BIT_W       = 5;
    localparam int MAC_W       = 48;
    localparam int CRC_W       = 32;
    localparam int INDEX_W     = 8;
    localparam int COUNT_W     = 4;

    // used words in each mode, capped at the physical depth
    localparam logic [COUNT_W-1:0] WIDE_WORDS =
        COUNT_W'(TABLE_WORDS > MAX_WORDS ? MAX_WORDS : TABLE_WORDS);
    localparam logic [COUNT_W-1:0] NARROW_WORDS = COUNT_W'(2);

    // reflected crc-32
    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [5:0]       CRC_LAST = 6'(MAC_W - 1);

    // commands
    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } opcode_t;

    // configuration register indexes
    localparam logic CFG_WIDE_TABLE    = 1'b0;
    localparam logic CFG_ALL_MULTICAST = 1'b1;

    // crc unit status
    typedef struct packed {
        logic busy;
        logic done;
    } crc_status_t;

    // table write command
    typedef struct packed {
        logic               clear;
        logic               fill;
        logic               set;
        logic [SEL_W-1:0]   set_word;
        logic [BIT_W-1:0]   set_bit;
        logic [COUNT_W-1:0] used_words;
    } tbl_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/mhtb_crc_serial.sv =====
`default_nettype none
module mhtb_crc_serial (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [mhtb_pkg::MAC_W-1:0]    mac,
    output mhtb_pkg::crc_status_t              status,
    output logic      [mhtb_pkg::CRC_W-1:0]    crc
);

    logic [mhtb_pkg::CRC_W-1:0] crc_reg, crc_next;
    logic [mhtb_pkg::MAC_W-1:0] mac_reg, mac_next;
    logic [5:0]                 cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic                       fb;

    // one address bit per cycle, lsb first
    always_comb
    begin
        fb        = crc_reg[0] ^ mac_reg[0];
        crc_next  = crc_reg;
        mac_next  = mac_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            crc_next  = mhtb_pkg::CRC_INIT;
            mac_next  = mac;
            cnt_next  = mhtb_pkg::CRC_LAST;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            crc_next = {1'b0, crc_reg[mhtb_pkg::CRC_W-1:1]}
                     ^ (fb ? mhtb_pkg::CRC_POLY : '0);
            mac_next = {1'b0, mac_reg[mhtb_pkg::MAC_W-1:1]};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        crc_reg <= crc_next;
        mac_reg <= mac_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign crc         = crc_reg;

endmodule
`default_nettype wire

// ===== rtl/core/mhtb_table.sv =====
`default_nettype none
module mhtb_table (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire mhtb_pkg::tbl_cmd_t              cmd,
    input  wire logic [mhtb_pkg::SEL_W-1:0]      rd_sel,
    output logic      [mhtb_pkg::WORD_W-1:0]     rd_word
);

    logic [mhtb_pkg::WORD_W-1:0] filter_word_reg [mhtb_pkg::MAX_WORDS];

    // one register per table word
    for (genvar g = 0; g < mhtb_pkg::MAX_WORDS; g++)
    begin : g_word
        localparam logic [mhtb_pkg::SEL_W-1:0] WORD_ID = mhtb_pkg::SEL_W'(g);
        logic word_used;
        logic [mhtb_pkg::WORD_W-1:0] word_next;

        always_comb
        begin
            word_used = {1'b0, WORD_ID} < cmd.used_words;
            word_next = filter_word_reg[g];
            if (cmd.clear && word_used)
                word_next = cmd.fill ? '1 : '0;
            else if (cmd.set && (cmd.set_word == WORD_ID))
                word_next = filter_word_reg[g]
                          | (mhtb_pkg::WORD_W'(1) << cmd.set_bit);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                filter_word_reg[g] <= '0;
            else
                filter_word_reg[g] <= word_next;
        end
    end

    // word read
    assign rd_word = filter_word_reg[rd_sel];

endmodule
`default_nettype wire

// ===== rtl/core/multicast_hash_table_builder.sv =====
// add: result beat after the bit-serial crc over the 48-bit address, the crc done
// flag and a finish step that updates the table
// clear, read, no-op: skip the crc and go from idle straight to the finish step
// input ready only in idle, so a new command is taken only once the last one has
// committed; a result held by m_tready low stalls the finish step
// rst_n asynchronous active low: table words and both config registers clear to zero
`default_nettype none
module multicast_hash_table_builder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration writes
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic        cfg_wdata,
    // command stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,    // [47:0] mac_address, [50:48] word_select
    input  wire logic [1:0]  s_tuser,    // [1:0] opcode
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata,    // [7:0] hash_index, [39:8] table_word
    output logic      [0:0]  m_tuser     // [0] word_valid
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_CRC    = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic                          wide_reg, allm_reg;
    mhtb_pkg::opcode_t             op_reg, op_next;
    logic [mhtb_pkg::SEL_W-1:0]    sel_reg, sel_next;

    logic                          out_valid_reg, out_valid_next;
    logic [mhtb_pkg::INDEX_W-1:0]  out_index_reg, out_index_next;
    logic [mhtb_pkg::WORD_W-1:0]   out_word_reg, out_word_next;
    logic                          out_flag_reg, out_flag_next;

    logic                          accept, commit, crc_start;
    mhtb_pkg::crc_status_t         crc_status;
    logic [mhtb_pkg::CRC_W-1:0]    crc;
    logic [mhtb_pkg::INDEX_W-1:0]  crc_low, crc_rev, hash_idx;
    logic [mhtb_pkg::SEL_W-1:0]    hash_word;
    logic [mhtb_pkg::COUNT_W-1:0]  used_words;
    logic                          add_in_range, read_in_range;
    mhtb_pkg::tbl_cmd_t            tbl_cmd;
    logic [mhtb_pkg::SEL_W-1:0]    rd_sel;
    logic [mhtb_pkg::WORD_W-1:0]   rd_word;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign commit    = (state_reg == ST_FINISH) && (!out_valid_reg || m_tready);
    assign crc_start = accept && (mhtb_pkg::opcode_t'(s_tuser) == mhtb_pkg::OP_ADD);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_reg <= 1'b0;
            allm_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mhtb_pkg::CFG_WIDE_TABLE:    wide_reg <= cfg_wdata;
                mhtb_pkg::CFG_ALL_MULTICAST: allm_reg <= cfg_wdata;
                default:                     ;
            endcase
        end
    end

    mhtb_crc_serial u_crc (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (crc_start),
        .mac    (s_tdata[47:0]),
        .status (crc_status),
        .crc    (crc)
    );

    // hash index from the inverted, bit-reversed low crc byte, shifted right by two in narrow mode
    always_comb
    begin
        crc_low = ~crc[mhtb_pkg::INDEX_W-1:0];
        for (int i = 0; i < mhtb_pkg::INDEX_W; i++)
            crc_rev[i] = crc_low[mhtb_pkg::INDEX_W-1-i];
        hash_idx  = wide_reg ? crc_rev : {2'b00, crc_rev[7:2]};
        hash_word = hash_idx[7:5];
    end

    assign used_words    = wide_reg ? mhtb_pkg::WIDE_WORDS : mhtb_pkg::NARROW_WORDS;
    assign add_in_range  = {1'b0, hash_word} < used_words;
    assign read_in_range = {1'b0, sel_reg} < used_words;
    assign rd_sel        = (op_reg == mhtb_pkg::OP_ADD) ? hash_word : sel_reg;

    // table write command, issued once on commit
    always_comb
    begin
        tbl_cmd.clear      = commit && (op_reg == mhtb_pkg::OP_CLEAR);
        tbl_cmd.fill       = allm_reg;
        tbl_cmd.set        = commit && (op_reg == mhtb_pkg::OP_ADD) && add_in_range;
        tbl_cmd.set_word   = hash_word;
        tbl_cmd.set_bit    = hash_idx[4:0];
        tbl_cmd.used_words = used_words;
    end

    mhtb_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (tbl_cmd),
        .rd_sel  (rd_sel),
        .rd_word (rd_word)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        sel_next   = sel_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next    = mhtb_pkg::opcode_t'(s_tuser);
                    sel_next   = s_tdata[50:48];
                    state_next = crc_start ? ST_CRC : ST_FINISH;
                end
            end
            ST_CRC:
            begin
                if (crc_status.done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (commit)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // result beat
    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        out_index_next = out_index_reg;
        out_word_next  = out_word_reg;
        out_flag_next  = out_flag_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
            out_index_next = '0;
            out_word_next  = '0;
            out_flag_next  = 1'b0;
            unique case (op_reg)
                mhtb_pkg::OP_CLEAR:
                begin
                    out_word_next = allm_reg ? '1 : '0;
                    out_flag_next = 1'b1;
                end
                mhtb_pkg::OP_ADD:
                begin
                    out_index_next = hash_idx;
                    if (add_in_range)
                    begin
                        out_word_next = rd_word
                                      | (mhtb_pkg::WORD_W'(1) << hash_idx[4:0]);
                        out_flag_next = 1'b1;
                    end
                end
                mhtb_pkg::OP_READ:
                begin
                    if (read_in_range)
                    begin
                        out_word_next = rd_word;
                        out_flag_next = 1'b1;
                    end
                end
                mhtb_pkg::OP_NOP:
                    ;
                default:
                    ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        sel_reg       <= sel_next;
        out_index_reg <= out_index_next;
        out_word_reg  <= out_word_next;
        out_flag_reg  <= out_flag_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {out_word_reg, out_index_reg};
    assign m_tuser[0] = out_flag_reg;

`ifndef SYNTH
    // crc finishes only while the sequencer waits on it
    a_crc_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        crc_status.done |-> (state_reg == ST_CRC))
        else $error("crc done outside crc state");

    // an accepted add starts the crc unit
    a_add_starts_crc: assert property (@(posedge clk) disable iff (!rst_n)
        crc_start |=> (crc_status.busy && (state_reg == ST_CRC)))
        else $error("add did not start crc");

    // an unused word never carries data
    a_invalid_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && !out_flag_next) |=> (out_word_reg == '0))
        else $error("invalid word with nonzero data");

    // a commit leaves a valid result and returns the sequencer to idle
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (out_valid_reg && (state_reg == ST_IDLE)))
        else $error("commit lost");
`endif

endmodule
`default_nettype wire
